@@ rtl/core/rnps_pkg.sv @@
package rnps_pkg;

  localparam int MAX_TARGETS_DEF = 16;
  localparam int COORD_BITS_DEF  = 20;
  localparam int IDX_BITS        = 6;
  localparam int DIST_BITS       = 42;
  localparam int RADIUS_BITS     = 16;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 16'd300;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_POINT  = 2'd2,
    OP_REPORT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RPT_READ,
    ST_RPT_LOAD
  } state_t;

endpackage

@@ rtl/core/rnps_in_if.sv @@
interface rnps_in_if #(
  parameter int COORD_BITS = rnps_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   op;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic                         point_valid;

  modport source (output valid, op, coord_x, coord_y, coord_z, point_valid, input ready);
  modport sink (input valid, op, coord_x, coord_y, coord_z, point_valid, output ready);
endinterface

@@ rtl/core/rnps_out_if.sv @@
interface rnps_out_if #(
  parameter int COORD_BITS = rnps_pkg::COORD_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [rnps_pkg::IDX_BITS-1:0]     target_index;
  logic                              found;
  logic signed [COORD_BITS-1:0]      hit_x;
  logic signed [COORD_BITS-1:0]      hit_y;
  logic signed [COORD_BITS-1:0]      hit_z;
  logic [rnps_pkg::DIST_BITS-1:0]    dist_sq;
  logic                              last_result;

  modport source (output valid, target_index, found, hit_x, hit_y, hit_z, dist_sq,
                  last_result, input ready);
  modport sink (input valid, target_index, found, hit_x, hit_y, hit_z, dist_sq,
                last_result, output ready);
endinterface

@@ rtl/core/radius_nearest_point_snap.sv @@
// Radius nearest-point snap. Holds up to MAX_TARGETS target XY positions and, per target,
// the nearest valid point (squared XY distance at most radius_mm squared, earlier point
// wins ties). Clear and append complete without leaving the idle state. A point runs
// through one shared squared-distance unit (table read, two squarers, add and compare),
// one target per cycle; the block takes the next transaction only once the last target
// has left the compare stage. An invalid point, or a point with no targets loaded,
// leaves the block idle. A report returns one result per loaded target, each through a
// table read and then a load of the output register, and waits while the sink stalls;
// the block takes the next transaction while the last result still waits in the output
// register. radius_mm resets to 300 and the user must see that it is written only while
// the block is idle; the block itself does not enforce this.
module radius_nearest_point_snap #(
  parameter int MAX_TARGETS = rnps_pkg::MAX_TARGETS_DEF,
  parameter int COORD_BITS  = rnps_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  rnps_in_if.sink                          item,
  rnps_out_if.source                       result,
  input  logic                             cfg_wr_en,
  input  logic [rnps_pkg::RADIUS_BITS-1:0] cfg_wr_data
);

  localparam int AW   = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CW   = $clog2(MAX_TARGETS + 1);
  localparam int DW   = COORD_BITS + 1;
  localparam int SQW  = 2 * DW;
  localparam int SW   = SQW + 1;
  localparam int RW   = 2 * rnps_pkg::RADIUS_BITS;
  localparam int CMPW = (SW > rnps_pkg::DIST_BITS) ? SW : rnps_pkg::DIST_BITS;

  rnps_pkg::state_t state, state_next;
  rnps_pkg::op_t    op_in;

  logic [rnps_pkg::RADIUS_BITS-1:0] radius;
  logic [RW-1:0]                    rad2;
  logic [CW-1:0]                    loaded_count;
  logic [CW-1:0]                    idx;
  logic [MAX_TARGETS-1:0]           found_flags;
  logic signed [COORD_BITS-1:0]     pt_x, pt_y, pt_z;

  logic signed [COORD_BITS-1:0]     tgt_x_mem [MAX_TARGETS];
  logic signed [COORD_BITS-1:0]     tgt_y_mem [MAX_TARGETS];
  logic signed [COORD_BITS-1:0]     best_x_mem [MAX_TARGETS];
  logic signed [COORD_BITS-1:0]     best_y_mem [MAX_TARGETS];
  logic signed [COORD_BITS-1:0]     best_z_mem [MAX_TARGETS];
  logic [rnps_pkg::DIST_BITS-1:0]   best_d_mem [MAX_TARGETS];

  logic signed [COORD_BITS-1:0]     tx_rd, ty_rd, bx_rd, by_rd, bz_rd;
  logic [rnps_pkg::DIST_BITS-1:0]   bd_rd;
  logic                             fl_rd;

  logic                             s1_vld;
  logic [AW-1:0]                    s1_idx;
  logic                             s2_vld;
  logic [AW-1:0]                    s2_idx;
  logic                             s2_fl;
  logic [rnps_pkg::DIST_BITS-1:0]   s2_bd;
  logic [SQW-1:0]                   sq_x, sq_y;

  logic signed [DW-1:0]             dx, dy;
  logic signed [SQW-1:0]            px, py;
  logic [SW-1:0]                    d2;
  logic [CMPW-1:0]                  d2e, r2e, bde;
  logic                             wr_best;

  logic                             take, iss, rpt_load, rpt_last, full;
  logic [AW-1:0]                    rd_addr, ld_addr;

  logic                             out_vld;
  logic [rnps_pkg::IDX_BITS-1:0]    out_index;
  logic                             out_found;
  logic signed [COORD_BITS-1:0]     out_x, out_y, out_z;
  logic [rnps_pkg::DIST_BITS-1:0]   out_dist;
  logic                             out_last;

  assign op_in      = rnps_pkg::op_t'(item.op);
  assign item.ready = (state == rnps_pkg::ST_IDLE);
  assign take       = item.valid && item.ready;
  assign full       = (loaded_count == CW'(MAX_TARGETS));
  assign rd_addr    = idx[AW-1:0];
  assign ld_addr    = loaded_count[AW-1:0];
  assign rpt_last   = ((idx + CW'(1)) == loaded_count);

  // shared squared-distance unit: difference and square, then add and compare
  assign dx      = DW'(pt_x) - DW'(tx_rd);
  assign dy      = DW'(pt_y) - DW'(ty_rd);
  assign px      = dx * dx;
  assign py      = dy * dy;
  assign d2      = SW'(sq_x) + SW'(sq_y);
  assign d2e     = CMPW'(d2);
  assign r2e     = CMPW'(rad2);
  assign bde     = CMPW'(s2_bd);
  assign wr_best = s2_vld && (d2e <= r2e) && (!s2_fl || (d2e < bde));

  always_comb begin
    state_next = state;
    iss        = 1'b0;
    rpt_load   = 1'b0;
    case (state)
      rnps_pkg::ST_IDLE: begin
        if (take) begin
          case (op_in)
            rnps_pkg::OP_POINT: begin
              if (item.point_valid && (loaded_count != '0)) state_next = rnps_pkg::ST_SCAN;
            end
            rnps_pkg::OP_REPORT: begin
              if (loaded_count != '0) state_next = rnps_pkg::ST_RPT_READ;
            end
            default: ;
          endcase
        end
      end
      rnps_pkg::ST_SCAN: begin
        iss = (idx < loaded_count);
        // finish once the last target has left the compare stage
        if (!iss && !s1_vld && !s2_vld) state_next = rnps_pkg::ST_IDLE;
      end
      rnps_pkg::ST_RPT_READ: begin
        state_next = rnps_pkg::ST_RPT_LOAD;
      end
      rnps_pkg::ST_RPT_LOAD: begin
        if (!out_vld || result.ready) begin
          rpt_load   = 1'b1;
          state_next = rpt_last ? rnps_pkg::ST_IDLE : rnps_pkg::ST_RPT_READ;
        end
      end
      default: state_next = rnps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rnps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= rnps_pkg::RADIUS_RESET;
      loaded_count <= '0;
      found_flags  <= '0;
      idx          <= '0;
      s1_vld       <= 1'b0;
      s2_vld       <= 1'b0;
      out_vld      <= 1'b0;
    end else begin
      if (cfg_wr_en) radius <= cfg_wr_data;
      s1_vld <= iss;
      s2_vld <= s1_vld;
      if (take) begin
        idx <= '0;
        case (op_in)
          rnps_pkg::OP_CLEAR: begin
            loaded_count <= '0;
            found_flags  <= '0;
          end
          rnps_pkg::OP_APPEND: begin
            if (!full) begin
              loaded_count         <= loaded_count + CW'(1);
              found_flags[ld_addr] <= 1'b0;
            end
          end
          default: ;
        endcase
      end else if (iss || rpt_load) begin
        idx <= idx + CW'(1);
      end
      if (wr_best) found_flags[s2_idx] <= 1'b1;
      if (rpt_load) begin
        out_vld <= 1'b1;
      end else if (result.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  // target table: written on append, read at the sequencer index
  always_ff @(posedge clk) begin
    if (take && (op_in == rnps_pkg::OP_APPEND) && !full) begin
      tgt_x_mem[ld_addr] <= item.coord_x;
      tgt_y_mem[ld_addr] <= item.coord_y;
    end
    tx_rd <= tgt_x_mem[rd_addr];
    ty_rd <= tgt_y_mem[rd_addr];
  end

  // best-hit table: written from the compare stage
  always_ff @(posedge clk) begin
    if (wr_best) begin
      best_x_mem[s2_idx] <= pt_x;
      best_y_mem[s2_idx] <= pt_y;
      best_z_mem[s2_idx] <= pt_z;
      best_d_mem[s2_idx] <= d2e[rnps_pkg::DIST_BITS-1:0];
    end
    bx_rd <= best_x_mem[rd_addr];
    by_rd <= best_y_mem[rd_addr];
    bz_rd <= best_z_mem[rd_addr];
    bd_rd <= best_d_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pt_x <= item.coord_x;
      pt_y <= item.coord_y;
      pt_z <= item.coord_z;
      rad2 <= RW'(radius) * RW'(radius);
    end
    fl_rd  <= found_flags[rd_addr];
    s1_idx <= rd_addr;
    s2_idx <= s1_idx;
    s2_fl  <= fl_rd;
    s2_bd  <= bd_rd;
    sq_x   <= $unsigned(px);
    sq_y   <= $unsigned(py);
    if (rpt_load) begin
      out_index <= rnps_pkg::IDX_BITS'(idx);
      out_found <= fl_rd;
      out_x     <= fl_rd ? bx_rd : '0;
      out_y     <= fl_rd ? by_rd : '0;
      out_z     <= fl_rd ? bz_rd : '0;
      out_dist  <= fl_rd ? bd_rd : '0;
      out_last  <= rpt_last;
    end
  end

  assign result.valid        = out_vld;
  assign result.target_index = out_index;
  assign result.found        = out_found;
  assign result.hit_x        = out_x;
  assign result.hit_y        = out_y;
  assign result.hit_z        = out_z;
  assign result.dist_sq      = out_dist;
  assign result.last_result  = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CW'(MAX_TARGETS))
    else $error("target count beyond capacity");

  a_pipe_drained: assert property (@(posedge clk) disable iff (rst)
    (state != rnps_pkg::ST_SCAN) |-> (!s1_vld && !s2_vld))
    else $error("distance pipeline busy outside a scan");

  a_best_sets_flag: assert property (@(posedge clk) disable iff (rst)
    wr_best |=> found_flags[$past(s2_idx)])
    else $error("best entry written without its found flag");

  a_report_index: assert property (@(posedge clk) disable iff (rst)
    (state == rnps_pkg::ST_RPT_LOAD) |-> (idx < loaded_count))
    else $error("report index past loaded targets");

endmodule
